>>> rtl/ibwt_pkg.sv
// ----------------------------------------------------------------------------
// ibwt_pkg
// Shared types and constants of the inverse BWT block decoder.
// ----------------------------------------------------------------------------
package ibwt_pkg;
    localparam int BlockSize = 1024;
    localparam int AddrW = $clog2(BlockSize);
    localparam int CntW = AddrW + 1;
    localparam int SymN = 256;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_START = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_NONE  = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
        logic [9:0] primary_index;
    } t_in;

    typedef struct packed {
        logic [7:0] decoded_byte;
        logic       last_byte;
        logic [1:0] status;
    } t_out;
endpackage

>>> rtl/ibwt_if.sv
// ----------------------------------------------------------------------------
// ibwt_in_if / ibwt_out_if
// Valid/ready channels of the decoder.
// ----------------------------------------------------------------------------
interface ibwt_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic [9:0] primary_index;
    modport source(output valid, kind, byte_value, primary_index, input ready);
    modport sink(input valid, kind, byte_value, primary_index, output ready);
endinterface

interface ibwt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] decoded_byte;
    logic       last_byte;
    logic [1:0] status;
    modport source(output valid, decoded_byte, last_byte, status, input ready);
    modport sink(input valid, decoded_byte, last_byte, status, output ready);
endinterface

>>> rtl/ibwt_ram.sv
// ----------------------------------------------------------------------------
// ibwt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ibwt_ram #(
    parameter int Width = 8,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/ibwt_front.sv
// ----------------------------------------------------------------------------
// ibwt_front
// Accept input items, drop unused kinds, queue the rest for the engine.
// ----------------------------------------------------------------------------
module ibwt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ibwt_in_if.sink       i_in,
    output logic          o_q_valid,
    output ibwt_pkg::t_in o_q_item,
    input  logic          i_q_pop
);
    import ibwt_pkg::*;

    logic [1:0] r_cnt;
    logic       r_wp;
    logic       r_rp;
    t_in        r_q [2];
    logic       w_push;

    assign i_in.ready = (r_cnt != 2'd2);
    assign w_push = i_in.valid && i_in.ready && (i_in.kind != KIND_NONE);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= '{i_in.kind, i_in.byte_value, i_in.primary_index};
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end
endmodule

>>> rtl/ibwt_engine.sv
// ----------------------------------------------------------------------------
// ibwt_engine
// Carry out loads, decodes and reads; clear, count, prefix, map and walk phases.
// ----------------------------------------------------------------------------
module ibwt_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  ibwt_pkg::t_in i_q_item,
    output logic          o_q_pop,
    ibwt_out_if.source    o_out
);
    import ibwt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_CNT_RD, S_CNT_WAIT, S_CNT_WR, S_PRE_RD, S_PRE_WAIT,
        S_PRE_WR, S_MAP_RD, S_MAP_WAIT, S_MAP_WR, S_WALK_RD, S_WALK_WAIT,
        S_RD_WAIT
    } t_state;

    t_state          r_state;
    logic [CntW-1:0] r_load_count;
    logic [CntW-1:0] r_read_ptr;
    logic            r_ready;
    logic [CntW-1:0] r_i;
    logic [AddrW-1:0] r_row;
    logic [CntW-1:0] r_sum;
    logic [7:0]      r_sym;
    logic            r_ov;
    t_out            r_out;
    logic            r_last;

    logic             col_we, lf_we, dec_we, cnt_we;
    logic [AddrW-1:0] col_wa, col_ra, lf_ra, dec_wa, dec_ra;
    logic [7:0]       col_wd, col_rd, dec_rd, cnt_wa, cnt_ra;
    logic [AddrW-1:0] lf_rd;
    logic [CntW-1:0]  cnt_wd, cnt_rd;

    ibwt_ram #(.Width(8), .Depth(BlockSize)) u_col (
        .i_clk, .i_we(col_we), .i_waddr(col_wa), .i_wdata(col_wd),
        .i_raddr(col_ra), .o_rdata(col_rd));
    ibwt_ram #(.Width(AddrW), .Depth(BlockSize)) u_lf (
        .i_clk, .i_we(lf_we), .i_waddr(r_i[AddrW-1:0]), .i_wdata(cnt_rd[AddrW-1:0]),
        .i_raddr(lf_ra), .o_rdata(lf_rd));
    ibwt_ram #(.Width(8), .Depth(BlockSize)) u_dec (
        .i_clk, .i_we(dec_we), .i_waddr(dec_wa), .i_wdata(col_rd),
        .i_raddr(dec_ra), .o_rdata(dec_rd));
    ibwt_ram #(.Width(CntW), .Depth(SymN)) u_cnt (
        .i_clk, .i_we(cnt_we), .i_waddr(cnt_wa), .i_wdata(cnt_wd),
        .i_raddr(cnt_ra), .o_rdata(cnt_rd));

    logic w_take;
    assign w_take = (r_state == S_IDLE) && i_q_valid && !r_ov;
    assign o_q_pop = w_take;
    assign o_out.valid = r_ov;
    assign o_out.decoded_byte = r_out.decoded_byte;
    assign o_out.last_byte = r_out.last_byte;
    assign o_out.status = r_out.status;

    logic [CntW-1:0] w_lc_eff;
    assign w_lc_eff = r_ready ? '0 : r_load_count;

    always_comb begin
        col_we = 1'b0; col_wa = w_lc_eff[AddrW-1:0]; col_wd = i_q_item.byte_value;
        col_ra = r_i[AddrW-1:0];
        lf_we = 1'b0; lf_ra = r_row;
        dec_we = 1'b0; dec_wa = r_i[AddrW-1:0]; dec_ra = r_read_ptr[AddrW-1:0];
        cnt_we = 1'b0; cnt_wa = r_sym; cnt_wd = cnt_rd + 1'b1; cnt_ra = r_sym;
        unique case (r_state)
            S_IDLE: begin
                col_we = w_take && (t_kind'(i_q_item.kind) == KIND_LOAD)
                         && (w_lc_eff != CntW'(BlockSize));
            end
            S_CLR: begin
                cnt_we = 1'b1; cnt_wa = r_i[7:0]; cnt_wd = '0;
            end
            S_CNT_WAIT: cnt_ra = col_rd;
            S_CNT_WR: cnt_we = 1'b1;
            S_PRE_RD, S_PRE_WAIT: cnt_ra = r_i[7:0];
            S_PRE_WR: begin
                cnt_we = 1'b1; cnt_wa = r_i[7:0]; cnt_wd = r_sum;
            end
            S_MAP_WAIT: cnt_ra = col_rd;
            S_MAP_WR: begin
                lf_we = 1'b1;
                cnt_we = 1'b1;
            end
            S_WALK_RD: col_ra = r_row;
            S_WALK_WAIT: begin
                dec_we = 1'b1;
                lf_ra = r_row;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_load_count <= '0;
            r_read_ptr <= '0;
            r_ready <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (w_take) begin
                    unique case (t_kind'(i_q_item.kind))
                        KIND_LOAD: begin
                            r_ready <= 1'b0;
                            if (r_ready) begin
                                r_read_ptr <= '0;
                            end
                            r_load_count <= w_lc_eff + CntW'(w_lc_eff != CntW'(BlockSize));
                        end
                        KIND_START: begin
                            r_out.decoded_byte <= '0;
                            r_out.last_byte <= 1'b0;
                            if (r_load_count == '0) begin
                                r_ready <= 1'b0;
                                r_out.status <= ST_EMPTY;
                                r_ov <= 1'b1;
                            end else if ({1'b0, i_q_item.primary_index} >= r_load_count) begin
                                r_ready <= 1'b0;
                                r_out.status <= ST_RANGE;
                                r_ov <= 1'b1;
                            end else begin
                                r_row <= i_q_item.primary_index;
                                r_i <= '0;
                                r_state <= S_CLR;
                            end
                        end
                        KIND_READ: begin
                            if (r_ready && r_read_ptr < r_load_count) begin
                                r_last <= (r_read_ptr + 1'b1 == r_load_count);
                                r_read_ptr <= r_read_ptr + 1'b1;
                                r_state <= S_RD_WAIT;
                            end else begin
                                r_out <= '{8'd0, 1'b0, ST_NONE};
                                r_ov <= 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                S_CLR: begin
                    if (r_i == CntW'(SymN - 1)) begin
                        r_i <= '0;
                        r_state <= S_CNT_RD;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_CNT_RD: r_state <= S_CNT_WAIT;
                S_CNT_WAIT: begin
                    r_sym <= col_rd;
                    r_state <= S_CNT_WR;
                end
                S_CNT_WR: begin
                    if (r_i + 1'b1 == r_load_count) begin
                        r_i <= '0;
                        r_sum <= '0;
                        r_state <= S_PRE_RD;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_CNT_RD;
                    end
                end
                S_PRE_RD: r_state <= S_PRE_WAIT;
                S_PRE_WAIT: begin
                    r_sym <= r_i[7:0];
                    r_state <= S_PRE_WR;
                end
                S_PRE_WR: begin
                    r_sum <= r_sum + cnt_rd;
                    if (r_i == CntW'(SymN - 1)) begin
                        r_i <= '0;
                        r_state <= S_MAP_RD;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_PRE_RD;
                    end
                end
                S_MAP_RD: r_state <= S_MAP_WAIT;
                S_MAP_WAIT: begin
                    r_sym <= col_rd;
                    r_state <= S_MAP_WR;
                end
                S_MAP_WR: begin
                    if (r_i + 1'b1 == r_load_count) begin
                        r_i <= r_load_count - 1'b1;
                        r_state <= S_WALK_RD;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_MAP_RD;
                    end
                end
                S_WALK_RD: r_state <= S_WALK_WAIT;
                S_WALK_WAIT: begin
                    if (r_i == '0) begin
                        r_ready <= 1'b1;
                        r_read_ptr <= '0;
                        r_out <= '{8'd0, 1'b0, ST_OK};
                        r_ov <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_i <= r_i - 1'b1;
                        r_state <= S_WALK_RD;
                    end
                end
                S_RD_WAIT: begin
                    r_out <= '{dec_rd, r_last, ST_OK};
                    r_ov <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_WALK_WAIT && r_i != '0) begin
                r_row <= lf_rd;
            end
        end
    end
endmodule

>>> rtl/inverse_bwt_block_decoder.sv
// ----------------------------------------------------------------------------
// inverse_bwt_block_decoder
// Inverse Burrows-Wheeler transform of one block of up to 1024 bytes.
//
// Input channel i_in carries items of three kinds: load a column byte,
// start a decode with a primary index, read the next decoded byte.
// Output channel o_out returns one result per start or read item.
// A front queue of two entries takes items while the engine is busy;
// an accepted item is registered in the queue before the engine sees it.
// A load writes its byte into the column RAM and returns no result; a read
// passes through the decoded-byte RAM and S_RD_WAIT to the result register.
// A start runs symbol clearing one entry per cycle, then counting, the
// prefix pass and the map pass with a read, wait and write state per
// entry, then the chain walk through the column and map RAMs, one row
// per S_WALK_RD and S_WALK_WAIT pair.
// A stalled receiver holds the result register; the engine waits and
// the queue fills, then i_in.ready drops.
// Synchronous reset empties the queue, clears the load count, read
// pointer and decode flag; the RAMs keep their contents.
// ----------------------------------------------------------------------------
module inverse_bwt_block_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ibwt_in_if.sink   i_in,
    ibwt_out_if.source o_out
);
    import ibwt_pkg::*;

    logic q_valid, q_pop;
    t_in  q_item;

    ibwt_front u_front (
        .i_clk, .i_rst_n, .i_in,
        .o_q_valid(q_valid), .o_q_item(q_item), .i_q_pop(q_pop));

    ibwt_engine u_engine (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .i_q_item(q_item),
        .o_q_pop(q_pop), .o_out);

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid) else $error("result dropped");
    a_last_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.last_byte |-> o_out.status == ST_OK)
        else $error("last mark on failed item");
endmodule
